>>> rtl/int_to_ascii_dec_hex_unit_macros.svh
// Assertion macros for the top-level unit, which checks itself.
`ifndef INT_TO_ASCII_DEC_HEX_UNIT_MACROS_SVH
`define INT_TO_ASCII_DEC_HEX_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while reset is asserted.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is asserted.
`define ITOA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int WORD_BITS = 32;
  localparam int VALUE_W = 32;
  localparam int CHAR_W = 8;

  function automatic int dec_digits_f(input int bits);
    longint unsigned v;
    int n;
    v = (longint'(1) << bits) - 1;
    n = 0;
    while (v != 0) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int DEC_DIGITS = dec_digits_f(WORD_BITS);
  localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
  localparam int POS_W = $clog2(DEC_DIGITS);
  localparam int CMP_W = WORD_BITS + 4;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  typedef logic [9:0][CMP_W-1:0] mult_row_t;
  typedef mult_row_t [DEC_DIGITS-1:0] mult_tbl_t;

  // Entry [k][d] holds d * 10**k.
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t tbl;
    longint unsigned p;
    p = 1;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      for (int d = 0; d < 10; d++) begin
        tbl[k][d] = CMP_W'(p * longint'(d));
      end
      p = p * 10;
    end
    return tbl;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
  } in_data_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } out_data_t;

  typedef struct packed {
    logic load;
    logic emit_sign;
    logic step;
  } itoa_cmd_t;

  typedef struct packed {
    logic in_neg;
    logic slot_free;
    logic pos_zero;
  } itoa_sts_t;

endpackage

>>> rtl/itoa_ctrl.sv
module itoa_ctrl import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  itoa_sts_t sts,
  output itoa_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIGN = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = sts.in_neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.pos_zero) begin
            in_stall = 1'b0;
            if (in_valid) begin
              cmd.load = 1'b1;
              state_nxt = sts.in_neg ? ST_SIGN : ST_DIGIT;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/itoa_dp.sv
module itoa_dp import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_data_t  in_data,
  input  itoa_cmd_t cmd,
  output itoa_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  logic [WORD_BITS-1:0] mag_r;
  logic [WORD_BITS-1:0] mag_nxt;
  logic                 hex_r;
  logic [POS_W-1:0]     pos_r;
  logic                 started_r;
  logic                 out_valid_r;
  out_data_t            out_data_r;

  logic [WORD_BITS-1:0] in_word;
  logic                 in_neg;
  logic [3:0]           dec_digit;
  logic [3:0]           hex_digit;
  logic [3:0]           digit;
  logic [WORD_BITS-1:0] dec_rem;
  logic [CHAR_W-1:0]    digit_char;
  logic                 pos_zero;
  logic                 emit_digit;

  assign in_word = in_data.value[WORD_BITS-1:0];
  assign in_neg = (in_data.op == OP_DEC) && in_word[WORD_BITS-1];
  assign pos_zero = (pos_r == '0);

  always_comb begin
    dec_digit = 4'd0;
    for (int d = 1; d < 10; d++) begin
      if ({4'b0, mag_r} >= MULT_TBL[pos_r][d]) begin
        dec_digit = 4'(d);
      end
    end
  end

  assign dec_rem = WORD_BITS'({4'b0, mag_r} - MULT_TBL[pos_r][dec_digit]);
  assign hex_digit = 4'(mag_r >> {pos_r, 2'b00});
  assign digit = hex_r ? hex_digit : dec_digit;
  assign digit_char = (digit < 4'd10) ? (CH_ZERO + CHAR_W'(digit))
                                      : (CH_LOWER_A + CHAR_W'(digit - 4'd10));
  assign emit_digit = cmd.step && (started_r || (digit != 4'd0) || pos_zero);

  assign mag_nxt = in_neg ? (~in_word + WORD_BITS'(1)) : in_word;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_nxt;
      hex_r <= in_data.op;
      pos_r <= (in_data.op == OP_HEX) ? POS_W'(HEX_DIGITS - 1) : POS_W'(DEC_DIGITS - 1);
      started_r <= 1'b0;
    end else if (cmd.step) begin
      if (!hex_r) begin
        mag_r <= dec_rem;
      end
      pos_r <= pos_r - POS_W'(1);
      started_r <= started_r || (digit != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_data_r.char_code <= CH_MINUS;
      out_data_r.last <= 1'b0;
    end else if (emit_digit) begin
      out_data_r.char_code <= digit_char;
      out_data_r.last <= pos_zero;
    end
  end

  assign sts.in_neg = in_neg;
  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.pos_zero = pos_zero;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> rtl/int_to_ascii_dec_hex_unit.sv
// Integer to ASCII text converter, signed decimal or lowercase hexadecimal.
// The input channel (in_valid, in_stall, in_data) takes one transaction per
// word: op selects decimal (0) or hex (1), value holds the word. The output
// channel (out_valid, out_stall, out_data) gives one transaction per
// character, most significant digit first, with last set on the final one.
// A negative decimal word starts with '-'; zero gives a single '0'.
// After a word is taken the block walks its digit positions, one position
// per cycle while no character is held: ten positions in decimal, eight in
// hex, plus a sign state for a negative decimal word. Leading zero positions
// are walked but not sent. Each character is registered and is on out_data
// in the cycle after the cycle in which it is emitted. The next word is
// taken in the cycle of the final digit.
// A single output register holds each character; while a character waits
// under out_stall the walk pauses and the character holds. Synchronous reset
// (rst_n low) empties the output register and returns the controller to idle.
module int_to_ascii_dec_hex_unit import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

`include "int_to_ascii_dec_hex_unit_macros.svh"

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ITOA_ASSERT_NOW(a_no_overwrite, out_valid && out_stall, !(cmd.emit_sign || cmd.step), "character overwritten while stalled")
  `ITOA_ASSERT_NOW(a_one_action, 1'b1, $onehot0({cmd.emit_sign, cmd.step}), "sign and digit in one cycle")
  `ITOA_ASSERT_NOW(a_accept_loads, in_valid && !in_stall, cmd.load, "transaction taken without load")
  `ITOA_ASSERT_NXT(a_sign_first, cmd.emit_sign, out_valid && !out_data.last, "sign not sent as a leading character")

endmodule

>>> test/tb_int_to_ascii_dec_hex_unit.sv
module tb_int_to_ascii_dec_hex_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import itoa_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_data_t out_data;

  out_data_t char_q[$];
  int        fail_cnt = 0;
  int        chars_checked = 0;
  int        words_sent = 0;
  int        dec_words = 0;
  int        neg_words = 0;
  int        hex_words = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  bit        char_taken = 1'b0;
  int        rx_hold = 0;

  int_to_ascii_dec_hex_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Builds the expected character stream of one word, most significant digit first.
  function automatic void format_word(input in_data_t item);
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] mag;
    logic [CHAR_W-1:0]    text[$];
    logic [3:0]           digit;
    logic                 neg;
    int unsigned          radix;
    out_data_t            ch;
    word = item.value[WORD_BITS-1:0];
    neg = (item.op == OP_DEC) && word[WORD_BITS-1];
    mag = neg ? (~word + 1'b1) : word;
    radix = (item.op == OP_HEX) ? 16 : 10;
    do begin
      digit = 4'(mag % radix);
      if (digit < 10) begin
        text.push_front(CHAR_W'(CH_ZERO + digit));
      end else begin
        text.push_front(CHAR_W'(CH_LOWER_A + digit - 10));
      end
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      text.push_front(CH_MINUS);
    end
    foreach (text[i]) begin
      ch.char_code = text[i];
      ch.last = (i == text.size() - 1);
      char_q.push_back(ch);
    end
  endfunction

  task automatic send_word(input logic mode, input logic [VALUE_W-1:0] word);
    in_data_t item;
    int       gap;
    item.op = mode;
    item.value = word;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    format_word(item);
    words_sent++;
    if (mode == OP_HEX) begin
      hex_words++;
    end else begin
      dec_words++;
      if (word[WORD_BITS-1]) neg_words++;
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_word();
    logic [VALUE_W-1:0] w;
    logic [VALUE_W-1:0] p;
    p = 1;
    case ($urandom_range(0, 5))
      0, 1: w = $urandom;
      2: w = $urandom_range(0, 20);
      3: w = -$urandom_range(1, 1000);
      4: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        w = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) w = -w;
      end
      default: begin
        w = 1 << $urandom_range(0, VALUE_W - 1);
        if ($urandom_range(0, 1)) w = ~w;
      end
    endcase
    return w;
  endfunction

  task automatic test_directed();
    send_word(OP_DEC, 32'd0);
    send_word(OP_DEC, 32'd1);
    send_word(OP_DEC, 32'd9);
    send_word(OP_DEC, 32'd10);
    send_word(OP_DEC, 32'hffff_ffff);
    send_word(OP_DEC, 32'hffff_fff6);
    send_word(OP_DEC, 32'h7fff_ffff);
    send_word(OP_DEC, 32'h8000_0000);
    send_word(OP_DEC, 32'h8000_0001);
    send_word(OP_DEC, 32'd1000000000);
    send_word(OP_DEC, 32'd1234567890);
    send_word(OP_DEC, 32'd999999999);
    send_word(OP_HEX, 32'h0);
    send_word(OP_HEX, 32'hf);
    send_word(OP_HEX, 32'h10);
    send_word(OP_HEX, 32'hffff_ffff);
    send_word(OP_HEX, 32'h8000_0000);
    send_word(OP_HEX, 32'h7fff_ffff);
    send_word(OP_HEX, 32'hdead_beef);
    send_word(OP_HEX, 32'h0123_abcd);
    send_word(OP_HEX, 32'h89ab_cdef);
    send_word(OP_HEX, 32'h0000_000a);
    wait_drained();
  endtask

  task automatic test_random_words();
    for (int i = 0; i < 120; i++) begin
      if (i % 30 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end
      send_word(logic'($urandom_range(0, 1)), random_word());
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    for (int i = 0; i < 30; i++) begin
      send_word(logic'($urandom_range(0, 1)), random_word());
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 12; i++) begin
      send_word(logic'($urandom_range(0, 1)), random_word());
      if (i % 4 == 3) wait_drained();
    end
    wait_drained();
  endtask

  always @(negedge clk) begin : result_check
    out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      char_taken = 1'b1;
      chars_checked++;
      if (char_q.size() == 0) begin
        note_failure($sformatf("Unexpected character 0x%02h last %0b",
                               out_data.char_code, out_data.last));
      end else begin
        want = char_q.pop_front();
        if (want.char_code !== out_data.char_code || want.last !== out_data.last) begin
          note_failure($sformatf(
            "Mismatch at character %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
            chars_checked, want.char_code, want.last, out_data.char_code, out_data.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (char_taken) begin
      char_taken = 1'b0;
      rx_hold = rx_idle_on ? $urandom_range(0, 15) : 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold != 0);
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_words();
    test_back_to_back();
    test_drain_pause();
    repeat (24) @(posedge clk);
    $display("Sent %0d words: %0d decimal (%0d negative) and %0d hex.",
             words_sent, dec_words, neg_words, hex_words);
    $display("Checked %0d characters with random gaps and stalls on both sides.",
             chars_checked);
    if (fail_cnt == 0) begin
      $display("int_to_ascii_dec_hex_unit verification clean");
    end else begin
      $display("Failures: %0d", fail_cnt);
      $display("int_to_ascii_dec_hex_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d characters still expected.", char_q.size());
    $display("int_to_ascii_dec_hex_unit verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/int_to_ascii_dec_hex_unit.sv
test/tb_int_to_ascii_dec_hex_unit.sv
